// File: src/bre_pkg.sv
// Shared types and constants for the bitmap run-length scanline encoder.
// Used by every module in src; no dependencies of its own.
package bre_pkg;

  // Depth of the queue between the run tracker and the byte serializer.
  localparam int unsigned QueueDepth = 2;

  localparam int unsigned PaddrW = 3;

  localparam logic [7:0] ByteLimit   = 8'd255;
  localparam logic [7:0] NibbleLimit = 8'd127;
  localparam logic [7:0] MarkEsc     = 8'h00;
  localparam logic [7:0] MarkEol     = 8'h00;
  localparam logic [7:0] MarkEoi     = 8'h01;

  // Register indexes.
  localparam logic [PaddrW-3:0] RegNibbleMode = '0;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       line_end;
    logic       image_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       burst_last;
  } out_t;

  // Output burst caused by one input byte: optional closed run, optional line end.
  typedef struct packed {
    logic       has_flush;
    logic [7:0] flush_cnt;
    logic [7:0] flush_val;
    logic       has_eol;
    logic [7:0] eol_cnt;
    logic [7:0] eol_val;
    logic       image_end;
  } burst_t;

endpackage

// File: src/bre_front.sv
// Run tracker: accepts scanline bytes, extends or closes runs, queues bursts.
// Depends on bre_pkg.
module bre_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            nibble_mode_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  bre_pkg::in_t    in_data_i,
  output logic            push_o,
  output bre_pkg::burst_t push_data_o,
  input  logic            full_i
);
  import bre_pkg::*;

  logic [7:0] run_value_q, run_value_d;
  logic [7:0] run_count_q, run_count_d;
  logic       run_open_q, run_open_d;
  logic       accept;
  logic       extend;
  logic [7:0] limit;
  logic [7:0] step;
  logic [7:0] cnt_new;
  logic [7:0] val_new;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign limit      = nibble_mode_i ? NibbleLimit : ByteLimit;
  assign step       = nibble_mode_i ? 8'd2 : 8'd1;
  assign extend     = run_open_q && (in_data_i.pixel_byte == run_value_q)
                      && (run_count_q < limit);

  always_comb begin
    if (extend) begin
      cnt_new = run_count_q + step;
      val_new = run_value_q;
    end else begin
      cnt_new = step;
      val_new = in_data_i.pixel_byte;
    end
  end

  always_comb begin
    push_data_o.has_flush = !extend && run_open_q;
    push_data_o.flush_cnt = run_count_q;
    push_data_o.flush_val = run_value_q;
    push_data_o.has_eol   = in_data_i.line_end;
    push_data_o.eol_cnt   = cnt_new;
    push_data_o.eol_val   = val_new;
    push_data_o.image_end = in_data_i.image_end;
  end

  assign push_o = accept && (push_data_o.has_flush || in_data_i.line_end);

  always_comb begin
    run_value_d = run_value_q;
    run_count_d = run_count_q;
    run_open_d  = run_open_q;
    if (accept) begin
      if (in_data_i.line_end) begin
        run_value_d = '0;
        run_count_d = '0;
        run_open_d  = 1'b0;
      end else begin
        run_value_d = val_new;
        run_count_d = cnt_new;
        run_open_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_value_q <= '0;
      run_count_q <= '0;
      run_open_q  <= 1'b0;
    end else begin
      run_value_q <= run_value_d;
      run_count_q <= run_count_d;
      run_open_q  <= run_open_d;
    end
  end

endmodule

// File: src/bre_fifo.sv
// Short burst queue between the run tracker and the serializer.
// Depends on bre_pkg for the burst type.
module bre_fifo #(
  parameter int unsigned Depth = bre_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bre_pkg::burst_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output bre_pkg::burst_t head_o
);
  import bre_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  burst_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// File: src/bre_back.sv
// Byte serializer: walks each queued burst and drives the output register.
// Depends on bre_pkg.
module bre_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  bre_pkg::burst_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output bre_pkg::out_t   out_data_o
);
  import bre_pkg::*;

  logic [2:0] pos_q, pos_d;
  logic [2:0] idx;
  logic [2:0] last_idx;
  logic       load;
  logic       is_last;
  logic [7:0] sel_byte;
  logic       out_valid_q, out_valid_d;
  out_t       out_data_q, out_data_d;

  // Skip the flush pair when the burst has no closed run.
  assign idx      = pos_q + (head_i.has_flush ? 3'd0 : 3'd2);
  assign last_idx = head_i.has_eol ? 3'd5 : 3'd1;
  assign is_last  = (idx == last_idx);
  assign load     = valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o    = load && is_last;

  always_comb begin
    unique case (idx)
      3'd0:    sel_byte = head_i.flush_cnt;
      3'd1:    sel_byte = head_i.flush_val;
      3'd2:    sel_byte = head_i.eol_cnt;
      3'd3:    sel_byte = head_i.eol_val;
      3'd4:    sel_byte = MarkEsc;
      3'd5:    sel_byte = head_i.image_end ? MarkEoi : MarkEol;
      default: sel_byte = MarkEsc;
    endcase
  end

  always_comb begin
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (load) begin
      out_valid_d           = 1'b1;
      out_data_d.out_byte   = sel_byte;
      out_data_d.burst_last = is_last;
      pos_d                 = is_last ? 3'd0 : pos_q + 3'd1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: src/bmp_rle_scanline_encoder_top.sv
// Bitmap run-length scanline encoder, encoded mode, 8-bit or 4-bit pixels.
// An input byte's result bytes pass through the burst queue and then the output register.
// The run tracker takes one input byte per cycle while the burst queue is not full;
// the serializer sends one result byte per cycle while the output is not stalled.
// Reset clears the open run, the queue, the output valid flag and nibble_mode.
module bmp_rle_scanline_encoder_top #(
  parameter int unsigned QueueDepth = bre_pkg::QueueDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bre_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  bre_pkg::in_t               in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output bre_pkg::out_t              out_data_o
);
  import bre_pkg::*;

  logic   nibble_mode_q, nibble_mode_d;
  logic   reg_hit;
  logic   push, pop, full, q_valid;
  burst_t push_data, head;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[PaddrW-1:2] == RegNibbleMode);
  assign prdata  = reg_hit ? {31'd0, nibble_mode_q} : 32'd0;

  always_comb begin
    nibble_mode_d = nibble_mode_q;
    if (psel && penable && pwrite && reg_hit) begin
      nibble_mode_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nibble_mode_q <= 1'b0;
    end else begin
      nibble_mode_q <= nibble_mode_d;
    end
  end

  bre_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .nibble_mode_i (nibble_mode_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_data_i     (in_data_i),
    .push_o        (push),
    .push_data_o   (push_data),
    .full_i        (full)
  );

  bre_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  bre_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: bench/tb_top.sv
// Self-checking bench for bmp_rle_scanline_encoder_top: drives scanline bytes and
// configuration writes, predicts the run-length byte stream, compares every output transfer.
// Depends on bre_pkg and the encoder RTL in src.
`timescale 1ns / 1ps

module tb_top;
  import bre_pkg::*;

  localparam int unsigned DrainCycles = 8;
  localparam int unsigned QuietLimit  = 4000;
  localparam int unsigned HoldCycles  = 300;
  // First index past the register map.
  localparam logic [PaddrW-3:0] RegSpare = 1'b1;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PaddrW-1:0]  paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_stall_o;
  in_t                in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  out_t               out_data_o;

  // Predictor state: configuration and open run.
  logic               mode_nib;
  logic [7:0]         run_val;
  logic [7:0]         run_cnt;
  logic               run_on;

  out_t               exp_stream[$];
  int                 src_idle_pct;
  int                 rcv_idle_pct;
  int                 hold_left;
  int                 fail_count;
  int                 n_in;
  int                 n_out;

  bmp_rle_scanline_encoder_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic in_t mk_item(input logic [7:0] pix, input logic eol, input logic eoi);
    in_t item;
    item.pixel_byte = pix;
    item.line_end   = eol;
    item.image_end  = eoi;
    return item;
  endfunction

  // Extend or close the open run, flush on line end, queue the bytes this item causes.
  function automatic void encode_byte(input in_t item);
    logic [7:0] lim;
    logic [7:0] inc;
    logic [7:0] burst[$];
    out_t       res;
    lim = mode_nib ? NibbleLimit : ByteLimit;
    inc = mode_nib ? 8'd2 : 8'd1;
    if (run_on && item.pixel_byte == run_val && run_cnt < lim) begin
      run_cnt = run_cnt + inc;
    end else begin
      if (run_on) begin
        burst.push_back(run_cnt);
        burst.push_back(run_val);
      end
      run_on  = 1'b1;
      run_val = item.pixel_byte;
      run_cnt = inc;
    end
    if (item.line_end) begin
      burst.push_back(run_cnt);
      burst.push_back(run_val);
      burst.push_back(MarkEsc);
      burst.push_back(item.image_end ? MarkEoi : MarkEol);
      run_on  = 1'b0;
      run_cnt = '0;
      run_val = '0;
    end
    foreach (burst[i]) begin
      res.out_byte   = burst[i];
      res.burst_last = (i == burst.size() - 1);
      exp_stream.push_back(res);
    end
  endfunction

  task automatic send_item(input in_t item);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    encode_byte(item);
    n_in++;
  endtask

  // Drop valid, wait for every expected byte, then let the pipeline settle.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (exp_stream.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [PaddrW-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    if (wr && addr[PaddrW-1:2] == RegNibbleMode) mode_nib = wdata[0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write nibble_mode with random upper bits, then read it back.
  task automatic set_mode(input logic m);
    logic [31:0] rd;
    apb_access(1'b1, {RegNibbleMode, 2'b00}, {$urandom} & 32'hFFFF_FFFE | {31'd0, m}, rd);
    apb_access(1'b0, {RegNibbleMode, 2'b00}, 32'd0, rd);
    if (rd[0] !== mode_nib) begin
      $error("nibble_mode: expected %0d, actual %0d", mode_nib, rd[0]);
      fail_count++;
    end
  endtask

  task automatic test_directed();
    in_t items[$];
    set_mode(1'b0);
    items.push_back(mk_item(8'h00, 1'b1, 1'b0));
    items.push_back(mk_item(8'hFF, 1'b0, 1'b0));
    items.push_back(mk_item(8'hFF, 1'b0, 1'b1));  // image end without line end
    items.push_back(mk_item(8'hFF, 1'b0, 1'b0));
    items.push_back(mk_item(8'hA5, 1'b1, 1'b1));
    items.push_back(mk_item(8'h80, 1'b0, 1'b0));
    items.push_back(mk_item(8'h01, 1'b0, 1'b0));
    items.push_back(mk_item(8'h7F, 1'b1, 1'b0));
    foreach (items[i]) send_item(items[i]);
    wait_idle();
    items.delete();
    set_mode(1'b1);
    items.push_back(mk_item(8'h5A, 1'b1, 1'b0));  // odd-width line, one byte
    items.push_back(mk_item(8'h33, 1'b0, 1'b0));
    items.push_back(mk_item(8'h33, 1'b0, 1'b0));
    items.push_back(mk_item(8'h33, 1'b0, 1'b0));
    items.push_back(mk_item(8'h34, 1'b1, 1'b1));
    items.push_back(mk_item(8'hFF, 1'b0, 1'b0));
    items.push_back(mk_item(8'h00, 1'b0, 1'b1));
    items.push_back(mk_item(8'hFF, 1'b1, 1'b0));
    foreach (items[i]) send_item(items[i]);
    wait_idle();
  endtask

  task automatic test_register_map();
    logic [31:0] rd;
    set_mode(1'b0);
    apb_access(1'b1, {RegSpare, 2'b00}, 32'hFFFF_FFFF, rd);
    set_mode(1'b1);
    apb_access(1'b1, {RegSpare, 2'b00}, 32'h0000_0000, rd);
    apb_access(1'b0, {RegNibbleMode, 2'b00}, 32'd0, rd);
    if (rd[0] !== mode_nib) begin
      $error("nibble_mode: expected %0d, actual %0d", mode_nib, rd[0]);
      fail_count++;
    end
  endtask

  // Runs just long enough to hit the split in both modes.
  task automatic test_run_limits();
    set_mode(1'b0);
    for (int i = 0; i < 256; i++) send_item(mk_item(8'hC3, i == 255, 1'b0));
    wait_idle();
    set_mode(1'b1);
    for (int i = 0; i < 65; i++) send_item(mk_item(8'h96, i == 64, 1'b1));
    wait_idle();
  endtask

  // Switch mode with a run open: counts carry over, the new limit applies.
  task automatic test_mode_switch();
    set_mode(1'b1);
    for (int i = 0; i < 63; i++) send_item(mk_item(8'h3C, 1'b0, 1'b0));
    wait_idle();
    set_mode(1'b0);
    send_item(mk_item(8'h3C, 1'b0, 1'b0));
    wait_idle();
    // Count now sits at the nibble limit, so the next byte closes the run.
    set_mode(1'b1);
    send_item(mk_item(8'h3C, 1'b1, 1'b0));
    wait_idle();
    set_mode(1'b0);
    for (int i = 0; i < 3; i++) send_item(mk_item(8'h11, 1'b0, 1'b0));
    wait_idle();
    set_mode(1'b1);
    send_item(mk_item(8'h11, 1'b1, 1'b1));
    wait_idle();
  endtask

  // Hold the output off while the sender keeps offering bytes.
  task automatic test_backpressure();
    int saved_src;
    saved_src    = src_idle_pct;
    src_idle_pct = 0;
    hold_left    = HoldCycles;
    for (int i = 0; i < 40; i++) begin
      send_item(mk_item(8'($urandom_range(3)), (i % 4) == 3, 1'($urandom_range(1))));
    end
    wait_idle();
    src_idle_pct = saved_src;
  endtask

  // Lines of runs from a small palette, with noise bytes and stray image_end flags.
  task automatic send_random_lines(input int n_items);
    logic [7:0] palette[4];
    logic [7:0] val;
    logic       eol;
    int         sent;
    int         line_left;
    int         run_len;
    int         pick;
    foreach (palette[i]) palette[i] = 8'($urandom);
    sent      = 0;
    line_left = $urandom_range(1, 24);
    while (sent < n_items) begin
      val  = ($urandom_range(9) < 7) ? palette[$urandom_range(3)] : 8'($urandom);
      pick = $urandom_range(99);
      if (pick < 85)      run_len = $urandom_range(1, 8);
      else if (pick < 97) run_len = $urandom_range(9, 40);
      else                run_len = $urandom_range(100, 270);
      for (int k = 0; k < run_len && sent < n_items; k++) begin
        line_left--;
        eol = (line_left == 0);
        if (eol) begin
          line_left = ($urandom_range(9) == 0) ? $urandom_range(25, 400) : $urandom_range(1, 24);
        end
        send_item(mk_item(($urandom_range(99) < 8) ? 8'($urandom) : val, eol,
                          eol ? ($urandom_range(3) == 0) : ($urandom_range(9) == 0)));
        sent++;
      end
    end
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin src_idle_pct = 10; rcv_idle_pct = 84; end
        1: begin src_idle_pct = 84; rcv_idle_pct = 10; end
        default: begin src_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      for (int seg = 0; seg < 2; seg++) begin
        set_mode(1'((seg + phase) % 2));
        send_random_lines($urandom_range(8, 14));
        wait_idle();
      end
    end
  endtask

  initial begin : receiver
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < rcv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_out++;
      if (exp_stream.size() == 0) begin
        $error("out_byte: no transfer expected, actual %02h", out_data_o.out_byte);
        fail_count++;
      end else begin
        want = exp_stream.pop_front();
        if (out_data_o.out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, actual %02h", want.out_byte, out_data_o.out_byte);
          fail_count++;
        end
        if (out_data_o.burst_last !== want.burst_last) begin
          $error("burst_last: expected %0d, actual %0d", want.burst_last,
                 out_data_o.burst_last);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    mode_nib     = 1'b0;
    run_val      = '0;
    run_cnt      = '0;
    run_on       = 1'b0;
    hold_left    = 0;
    fail_count   = 0;
    n_in         = 0;
    n_out        = 0;
    src_idle_pct = 10;
    rcv_idle_pct = 84;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_register_map();
    test_run_limits();
    test_mode_switch();
    test_backpressure();
    test_random();

    $display("Sent %0d scanline bytes and checked %0d stream bytes in both pixel modes,",
             n_in, n_out);
    $display("with run splits, mode switches mid-run, a long output hold and three idle mixes.");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: bmp_rle_scanline_encoder_top.f
src/bre_pkg.sv
src/bre_front.sv
src/bre_fifo.sv
src/bre_back.sv
src/bmp_rle_scanline_encoder_top.sv
bench/tb_top.sv
